// ===== src/mlds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlds_pkg: multiplexed led display scanner package
// Operation codes, buffer layout constants and the segment, glyph and
// flow-light pattern tables.
// ----------------------------------------------------------------------------
package mlds_pkg;

    typedef enum logic [1:0] {
        OP_SCAN = 2'd0,
        OP_TIME = 2'd1,
        OP_FLOW = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    localparam int unsigned SCAN_POSITIONS = 15;
    localparam int unsigned MATRIX_ROWS    = 8;
    localparam int unsigned GLYPH_COUNT    = 7;
    localparam int unsigned FLOW_LEN       = 12;

    localparam logic [3:0] POS_SEC_UNITS  = 4'd8;
    localparam logic [3:0] POS_SEC_TENS   = 4'd9;
    localparam logic [3:0] POS_MIN_UNITS  = 4'd10;
    localparam logic [3:0] POS_MIN_TENS   = 4'd11;
    localparam logic [3:0] POS_HOUR_UNITS = 4'd12;
    localparam logic [3:0] POS_HOUR_TENS  = 4'd13;
    localparam logic [3:0] POS_BAR        = 4'd14;
    localparam logic [3:0] POS_LAST       = 4'd14;
    localparam logic [3:0] FLOW_LAST      = 4'd11;

    localparam logic [7:0] DP_CLEAR_MASK  = 8'h7f;
    localparam logic [7:0] LAST_SEC_RESET = 8'haa;

    // accepted input item as handed to the buffer
    typedef struct packed {
        t_op        op;
        logic [7:0] hour_bcd;
        logic [7:0] minute_bcd;
        logic [7:0] second_bcd;
        logic [3:0] weekday;
    } t_item;

    function automatic logic [7:0] seg_decode(input logic [3:0] nibble);
        logic [7:0] v;
        case (nibble)
            4'h0: v = 8'hc0;
            4'h1: v = 8'hf9;
            4'h2: v = 8'ha4;
            4'h3: v = 8'hb0;
            4'h4: v = 8'h99;
            4'h5: v = 8'h92;
            4'h6: v = 8'h82;
            4'h7: v = 8'hf8;
            4'h8: v = 8'h80;
            4'h9: v = 8'h90;
            4'ha: v = 8'h88;
            4'hb: v = 8'h83;
            4'hc: v = 8'hc6;
            4'hd: v = 8'ha1;
            4'he: v = 8'h86;
            default: v = 8'h8e;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] glyph_rows(input logic [2:0] wd);
        logic [63:0] v;
        // row 0 in the top byte
        case (wd)
            3'd0: v = 64'hFFC3818181C3E7FF;
            3'd1: v = 64'hFFE7E7E7E7E7E7FF;
            3'd2: v = 64'hE3DDDDEFF7FBFDC1;
            3'd3: v = 64'hFFC3BDDFE7DFBDC3;
            3'd4: v = 64'hCFD7DBDDDE00DFDF;
            3'd5: v = 64'hFFC3FBFBC3DFDFC3;
            3'd6: v = 64'hFFFBFBFBC3DBDBC3;
            default: v = 64'hFFFFFFFFFFFFFFFF;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] flow_pattern(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:  v = 8'h7f;
            4'd1:  v = 8'h3f;
            4'd2:  v = 8'h1f;
            4'd3:  v = 8'h0f;
            4'd4:  v = 8'h87;
            4'd5:  v = 8'hc3;
            4'd6:  v = 8'he1;
            4'd7:  v = 8'hf0;
            4'd8:  v = 8'hf8;
            4'd9:  v = 8'hfc;
            4'd10: v = 8'hfe;
            default: v = 8'hff;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/mlds_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlds_buffer: display buffer
// Holds the 15-byte active-low display buffer, the last second seen and the
// flow-light position; applies time updates and flow steps, one registered
// read port.
// ----------------------------------------------------------------------------
module mlds_buffer
    import mlds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_we,
    input  wire t_item      i_item,
    input  wire logic       i_re,
    input  wire logic [3:0] i_rd_addr,
    output logic      [7:0] o_rd_data
);

    logic [7:0] r_buf [0:SCAN_POSITIONS-1];
    logic [7:0] r_last_second;
    logic [3:0] r_flow_pos;
    logic [7:0] r_rd_data;

    logic        time_fire;
    logic        flow_fire;
    logic [63:0] glyph;

    assign time_fire = i_we && (i_item.op == OP_TIME) &&
                       (i_item.second_bcd != r_last_second);
    assign flow_fire = i_we && (i_item.op == OP_FLOW);
    assign glyph     = glyph_rows(i_item.weekday[2:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SCAN_POSITIONS; k++) begin
                r_buf[k] <= 8'h00;
            end
            r_last_second <= LAST_SEC_RESET;
            r_flow_pos    <= 4'd0;
        end else begin
            if (time_fire) begin
                r_buf[POS_HOUR_TENS]  <= seg_decode(i_item.hour_bcd[7:4]);
                r_buf[POS_HOUR_UNITS] <= seg_decode(i_item.hour_bcd[3:0]) & DP_CLEAR_MASK;
                r_buf[POS_MIN_TENS]   <= seg_decode(i_item.minute_bcd[7:4]);
                r_buf[POS_MIN_UNITS]  <= seg_decode(i_item.minute_bcd[3:0]) & DP_CLEAR_MASK;
                r_buf[POS_SEC_TENS]   <= seg_decode(i_item.second_bcd[7:4]);
                r_buf[POS_SEC_UNITS]  <= seg_decode(i_item.second_bcd[3:0]);
                // weekdays above six keep the matrix as it is
                if (i_item.weekday < 4'(GLYPH_COUNT)) begin
                    for (int r = 0; r < MATRIX_ROWS; r++) begin
                        r_buf[r] <= glyph[63-8*r -: 8];
                    end
                end
                r_last_second <= i_item.second_bcd;
            end
            if (flow_fire) begin
                r_buf[POS_BAR] <= flow_pattern(r_flow_pos);
                r_flow_pos     <= (r_flow_pos >= FLOW_LAST) ? 4'd0 : r_flow_pos + 4'd1;
            end
        end
    end

    // read data holds while no new read is taken
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_rd_addr <= POS_LAST) begin
                r_rd_data <= r_buf[i_rd_addr];
            end else begin
                r_rd_data <= r_buf[0];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== src/multiplexed_led_display_scanner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_led_display_scanner_top: multiplexed led display scanner
// Display buffer with time update, flow-light step and scan tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one command per transfer:
//   scan tick, time update or flow-light step, with the BCD time fields and
//   the weekday. Output channel (o_valid / i_stall) carries one scan result
//   per enabled scan tick: the position driven and its active-low byte.
//   One command is taken every cycle while o_stall is low; a scan result is
//   in the output register in the cycle after its transfer. Updates land in
//   the buffer at the transfer edge; a scan in the next cycle already sees them.
//   While the receiver stalls and a result waits, only scan ticks that would
//   give a new result are held off; the other commands keep flowing.
//   The APB register scan_enable (offset 0) suspends scanning when 0.
//   Reset clears the buffer to zero, the scan and flow positions to zero,
//   sets the last second to 0xaa and scan_enable to 1; no clearing pass.
// ----------------------------------------------------------------------------
module multiplexed_led_display_scanner_top
    import mlds_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_hour_bcd,
    input  wire logic [7:0]  i_minute_bcd,
    input  wire logic [7:0]  i_second_bcd,
    input  wire logic [3:0]  i_weekday,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [3:0]  o_digit_select,
    output logic      [7:0]  o_segment_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic       r_scan_enable;
    logic [3:0] r_scan_pos;
    logic       r_out_valid;
    logic [3:0] r_out_sel;

    logic       n_out_valid;
    logic [3:0] n_scan_pos;

    t_item      item;
    logic       accept;
    logic       scan_fire;
    logic       out_busy;
    logic       cfg_write;
    logic [7:0] rd_data;

    assign item.op         = t_op'(i_op);
    assign item.hour_bcd   = i_hour_bcd;
    assign item.minute_bcd = i_minute_bcd;
    assign item.second_bcd = i_second_bcd;
    assign item.weekday    = i_weekday;

    // the output register is still full for the next cycle
    assign out_busy  = r_out_valid && i_stall;
    assign o_stall   = out_busy && (item.op == OP_SCAN) && r_scan_enable;
    assign accept    = i_valid && !o_stall;
    assign scan_fire = accept && (item.op == OP_SCAN) && r_scan_enable;

    // the buffer read register doubles as the output data register
    mlds_buffer u_buffer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (accept),
        .i_item    (item),
        .i_re      (scan_fire),
        .i_rd_addr (r_scan_pos),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_out_valid = out_busy;
        n_scan_pos  = r_scan_pos;
        if (scan_fire) begin
            n_out_valid = 1'b1;
            n_scan_pos  = (r_scan_pos >= POS_LAST) ? 4'd0 : r_scan_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_scan_pos  <= 4'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_scan_pos  <= n_scan_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_fire) begin
            r_out_sel <= (r_scan_pos > POS_LAST) ? 4'd0 : r_scan_pos;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_digit_select = r_out_sel;
    assign o_segment_data = rd_data;

    // configuration port, register 0 covers byte offsets 0 to 3
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable <= 1'b1;
        end else if (cfg_write) begin
            r_scan_enable <= pwdata[0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_scan_enable};

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: multiplexed led display scanner testbench
// Drives scan ticks, time updates and flow-light steps over the command
// channel with random gaps and result stalls. A local model of the display
// buffer predicts every scan result, and each one is checked in order.
// scan_enable is switched over the APB port between phases.
// ----------------------------------------------------------------------------
module tb
    import mlds_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int PRINT_LIMIT    = 100;
    localparam int N_ITEMS        = 1500;
    localparam int DIGIT_BASE     = 8;
    localparam int BAR_POS        = 14;
    localparam logic [2:0] REG_SCAN_ENABLE = 3'd0;
    localparam logic [7:0] MDL_LAST_SEC_RESET = 8'haa;
    localparam logic [7:0] MDL_DP_CLEAR = 8'h7f;

    // entry 0 in the top byte
    localparam logic [127:0] SEG_ROM =
        128'hc0f9a4b0999282f8_80908883c6a1868e;
    localparam logic [447:0] GLYPH_ROM = {
        64'hFFC3818181C3E7FF, 64'hFFE7E7E7E7E7E7FF, 64'hE3DDDDEFF7FBFDC1,
        64'hFFC3BDDFE7DFBDC3, 64'hCFD7DBDDDE00DFDF, 64'hFFC3FBFBC3DFDFC3,
        64'hFFFBFBFBC3DBDBC3
    };
    localparam logic [95:0] FLOW_ROM = 96'h7f3f1f0f87c3e1f0f8fcfeff;

    typedef enum logic [1:0] {
        K_ITEM,
        K_DRAIN,
        K_CFG
    } t_kind;

    typedef enum logic [1:0] {
        APB_IDLE,
        APB_SETUP,
        APB_ACCESS
    } t_apb_state;

    typedef struct {
        t_kind      kind;
        logic [1:0] op;
        logic [7:0] hour_bcd;
        logic [7:0] minute_bcd;
        logic [7:0] second_bcd;
        logic [3:0] weekday;
        logic       cfg_value;
    } t_stim;

    typedef struct packed {
        logic [3:0] sel;
        logic [7:0] data;
    } t_result;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  in_op      = 2'd0;
    logic [7:0]  in_hour    = 8'd0;
    logic [7:0]  in_minute  = 8'd0;
    logic [7:0]  in_second  = 8'd0;
    logic [3:0]  in_weekday = 4'd0;
    logic        out_valid;
    logic        rx_stall   = 1'b0;
    logic [3:0]  out_sel;
    logic [7:0]  out_data;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = 3'd0;
    logic [31:0] pwdata     = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_stim      stim_q [$];
    t_result    exp_q [$];
    t_stim      drv_st;
    t_apb_state apb_state;
    t_result    mon_exp;
    logic       mon_xfer;

    int gap_cnt;
    int hold_cnt;
    int long_done;
    int stall_pick;
    int in_count;
    int out_count;
    int err_count;
    int idle_cnt;

    logic [7:0] mdl_buf [0:SCAN_POSITIONS-1];
    logic [3:0] mdl_scan_pos;
    logic [3:0] mdl_flow_pos;
    logic [7:0] mdl_last_second;
    logic       mdl_scan_enable;

    multiplexed_led_display_scanner_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_op           (in_op),
        .i_hour_bcd     (in_hour),
        .i_minute_bcd   (in_minute),
        .i_second_bcd   (in_second),
        .i_weekday      (in_weekday),
        .o_valid        (out_valid),
        .i_stall        (rx_stall),
        .o_digit_select (out_sel),
        .o_segment_data (out_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        if (err_count < PRINT_LIMIT) begin
            $display("ERROR %0t: %s", $time, msg);
        end
        err_count = err_count + 1;
    endtask

    task automatic finish_run();
        if (err_count == 0) begin
            $display("PASS multiplexed_led_display_scanner_top");
        end else begin
            $display("FAIL multiplexed_led_display_scanner_top");
        end
        $finish;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [7:0] rand_bcd(input int hi);
        int v;
        v = $urandom_range(0, hi);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic logic [7:0] mdl_seg(input logic [3:0] nib);
        return SEG_ROM[127 - 8*int'(nib) -: 8];
    endfunction

    task automatic mdl_reset();
        for (int k = 0; k < SCAN_POSITIONS; k++) begin
            mdl_buf[k] = 8'h00;
        end
        mdl_scan_pos    = 4'd0;
        mdl_flow_pos    = 4'd0;
        mdl_last_second = MDL_LAST_SEC_RESET;
        mdl_scan_enable = 1'b1;
    endtask

    task automatic mdl_put_digit(input int slot, input logic [3:0] nib, input logic with_dp);
        logic [7:0] v;
        v = mdl_seg(nib);
        if (with_dp) begin
            v = v & MDL_DP_CLEAR;
        end
        mdl_buf[DIGIT_BASE + slot] = v;
    endtask

    task automatic mdl_step(input logic [1:0] op, input logic [7:0] h, input logic [7:0] m,
                            input logic [7:0] s, input logic [3:0] wd);
        t_result res;
        case (op)
            OP_SCAN: begin
                if (mdl_scan_enable) begin
                    if (mdl_scan_pos >= 4'(SCAN_POSITIONS)) begin
                        mdl_scan_pos = 4'd0;
                    end
                    res.sel  = mdl_scan_pos;
                    res.data = mdl_buf[mdl_scan_pos];
                    exp_q.push_back(res);
                    mdl_scan_pos = (mdl_scan_pos == 4'(SCAN_POSITIONS - 1)) ?
                                   4'd0 : mdl_scan_pos + 4'd1;
                end
            end
            OP_TIME: begin
                if (s != mdl_last_second) begin
                    mdl_put_digit(5, h[7:4], 1'b0);
                    mdl_put_digit(4, h[3:0], 1'b1);
                    mdl_put_digit(3, m[7:4], 1'b0);
                    mdl_put_digit(2, m[3:0], 1'b1);
                    mdl_put_digit(1, s[7:4], 1'b0);
                    mdl_put_digit(0, s[3:0], 1'b0);
                    if (int'(wd) < GLYPH_COUNT) begin
                        for (int r = 0; r < MATRIX_ROWS; r++) begin
                            mdl_buf[r] = GLYPH_ROM[447 - 64*int'(wd) - 8*r -: 8];
                        end
                    end
                    mdl_last_second = s;
                end
            end
            OP_FLOW: begin
                if (int'(mdl_flow_pos) >= FLOW_LEN) begin
                    mdl_flow_pos = 4'd0;
                end
                mdl_buf[BAR_POS] = FLOW_ROM[95 - 8*int'(mdl_flow_pos) -: 8];
                mdl_flow_pos = (int'(mdl_flow_pos) == FLOW_LEN - 1) ?
                               4'd0 : mdl_flow_pos + 4'd1;
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_marker(input t_kind kind, input logic value);
        t_stim st;
        st.kind       = kind;
        st.op         = 2'd0;
        st.hour_bcd   = 8'd0;
        st.minute_bcd = 8'd0;
        st.second_bcd = 8'd0;
        st.weekday    = 4'd0;
        st.cfg_value  = value;
        stim_q.push_back(st);
    endtask

    // stimulus and reset
    initial begin : gen
        t_stim      st;
        logic [7:0] sec;
        int         r;
        sec = 8'h00;
        for (int i = 0; i < N_ITEMS; i++) begin
            if (i == 400 || i == 1200) begin
                push_marker(K_DRAIN, 1'b0);
            end
            if (i == 700) begin
                push_marker(K_DRAIN, 1'b0);
                push_marker(K_CFG, 1'b0);
            end
            if (i == 900) begin
                push_marker(K_DRAIN, 1'b0);
                push_marker(K_CFG, 1'b1);
            end
            st.kind      = K_ITEM;
            st.cfg_value = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 50) begin
                st.op = OP_SCAN;
            end else if (r < 75) begin
                st.op = OP_TIME;
            end else if (r < 92) begin
                st.op = OP_FLOW;
            end else begin
                st.op = OP_NONE;
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                // same second as before, so a time update may be ignored
            end else if (r < 88) begin
                sec = rand_bcd(59);
            end else if (r < 92) begin
                sec = MDL_LAST_SEC_RESET;
            end else begin
                sec = 8'($urandom_range(0, 255));
            end
            st.second_bcd = sec;
            if ($urandom_range(0, 9) == 0) begin
                st.hour_bcd   = 8'($urandom_range(0, 255));
                st.minute_bcd = 8'($urandom_range(0, 255));
            end else begin
                st.hour_bcd   = rand_bcd(23);
                st.minute_bcd = rand_bcd(59);
            end
            if ($urandom_range(0, 99) < 85) begin
                st.weekday = 4'($urandom_range(0, 6));
            end else begin
                st.weekday = 4'($urandom_range(7, 15));
            end
            stim_q.push_back(st);
        end
        push_marker(K_DRAIN, 1'b0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            gap_cnt   = 0;
            apb_state = APB_IDLE;
        end else if (apb_state == APB_SETUP) begin
            penable   <= 1'b1;
            apb_state = APB_ACCESS;
        end else if (apb_state == APB_ACCESS) begin
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            apb_state = APB_IDLE;
        end else if (in_valid && in_stall) begin
            // transfer still waiting, payload held
        end else if (gap_cnt > 0) begin
            in_valid <= 1'b0;
            gap_cnt  = gap_cnt - 1;
        end else if (stim_q.size() == 0) begin
            in_valid <= 1'b0;
        end else if (stim_q[0].kind == K_DRAIN) begin
            in_valid <= 1'b0;
            if (!in_valid && !out_valid && exp_q.size() == 0) begin
                void'(stim_q.pop_front());
            end
        end else if (stim_q[0].kind == K_CFG) begin
            drv_st    = stim_q.pop_front();
            in_valid  <= 1'b0;
            psel      <= 1'b1;
            pwrite    <= 1'b1;
            paddr     <= REG_SCAN_ENABLE;
            pwdata    <= {31'd0, drv_st.cfg_value};
            apb_state = APB_SETUP;
        end else begin
            drv_st     = stim_q.pop_front();
            in_valid   <= 1'b1;
            in_op      <= drv_st.op;
            in_hour    <= drv_st.hour_bcd;
            in_minute  <= drv_st.minute_bcd;
            in_second  <= drv_st.second_bcd;
            in_weekday <= drv_st.weekday;
            gap_cnt    = pick_gap();
        end
    end

    // receiver stall, with two long hold-offs
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_stall  <= 1'b0;
            hold_cnt  = 0;
            long_done = 0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            rx_stall <= 1'b1;
        end else if (long_done < 2 && in_count >= 300 + 600 * long_done) begin
            hold_cnt  = LONG_HOLD;
            long_done = long_done + 1;
            rx_stall  <= 1'b1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60) begin
                rx_stall <= 1'b0;
            end else if (stall_pick < 97) begin
                hold_cnt = $urandom_range(0, 3);
                rx_stall <= 1'b1;
            end else begin
                hold_cnt = $urandom_range(10, 40);
                rx_stall <= 1'b1;
            end
        end
    end

    // monitor, predictor, watchdog and end of run
    always @(posedge clk) begin
        if (!rst_n) begin
            mdl_reset();
            exp_q.delete();
            in_count  = 0;
            out_count = 0;
            idle_cnt  = 0;
        end else begin
            mon_xfer = 1'b0;
            if (out_valid && !rx_stall) begin
                mon_xfer = 1'b1;
                if (exp_q.size() == 0) begin
                    report($sformatf("unexpected result sel %0d data %02h",
                                     out_sel, out_data));
                end else begin
                    mon_exp = exp_q.pop_front();
                    if (out_sel !== mon_exp.sel || out_data !== mon_exp.data) begin
                        report($sformatf("result %0d: got sel %0d data %02h, expected sel %0d data %02h",
                                         out_count, out_sel, out_data,
                                         mon_exp.sel, mon_exp.data));
                    end
                end
                out_count = out_count + 1;
            end
            if (in_valid && !in_stall) begin
                mon_xfer = 1'b1;
                in_count = in_count + 1;
                mdl_step(in_op, in_hour, in_minute, in_second, in_weekday);
            end
            if (psel && penable && pwrite && pready) begin
                mon_xfer = 1'b1;
                if (paddr == REG_SCAN_ENABLE) begin
                    mdl_scan_enable = pwdata[0];
                end
            end
            if (mon_xfer) begin
                idle_cnt = 0;
            end else begin
                idle_cnt = idle_cnt + 1;
            end
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                report($sformatf("watchdog: no transfer for %0d cycles", idle_cnt));
                finish_run();
            end
            if (stim_q.size() == 0 && !in_valid && !out_valid && exp_q.size() == 0 &&
                !psel) begin
                finish_run();
            end
        end
    end

endmodule
